// ===== design/dtt_pkg.sv =====
// Shared types and constants for the deadline timer table.
// Used by dtt_order_cmp and deadline_timer_table; depends on nothing else.
package dtt_pkg;

   localparam int DEFAULT_NUM_SLOTS = 16;
   localparam int MODE_W            = 3;
   localparam int NOW_W             = 64;
   localparam int SLOT_ID_W         = 4;
   localparam int PERIOD_W          = 32;
   localparam int STATUS_W          = 2;
   localparam int REQ_DATA_W        = 104;
   localparam int RSP_DATA_W        = 72;
   localparam logic [NOW_W-1:0] ALL_ONES_MS = '1;

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD        = 3'd0,
      MODE_CANCEL     = 3'd1,
      MODE_REFRESH    = 3'd2,
      MODE_RESET      = 3'd3,
      MODE_POLL       = 3'd4,
      MODE_QUERY      = 3'd5,
      MODE_CANCEL_ALL = 3'd6
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_INACTIVE = 2'd1,
      STAT_FULL     = 2'd2,
      STAT_NONE_DUE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_EMIT,
      S_PER,
      S_ARM,
      S_OUT
   } state_type;

   typedef enum logic [1:0] {
      SCAN_EARLY,
      SCAN_DUE,
      SCAN_MIN_DUE,
      SCAN_MIN_ALL
   } scan_type;

   // deadline order: a ahead of b when its deadline is lower, lower slot on ties
   typedef struct packed {
      logic lt;
      logic eq;
      logic ahead;
   } cmp_type;

endpackage

// ===== design/dtt_order_cmp.sv =====
// Shared deadline comparator of the timer table: one 64-bit magnitude compare
// plus the slot tie-break. Depends on dtt_pkg.
module dtt_order_cmp
   import dtt_pkg::*;
#(
   parameter int SLOT_W = SLOT_ID_W
) (
   input  logic [NOW_W-1:0]  a_dl,
   input  logic [SLOT_W-1:0] a_idx,
   input  logic [NOW_W-1:0]  b_dl,
   input  logic [SLOT_W-1:0] b_idx,
   output cmp_type           res
);

   always_comb begin
      res.lt    = a_dl < b_dl;
      res.eq    = a_dl == b_dl;
      res.ahead = res.lt || (res.eq && (a_idx < b_idx));
   end

endmodule

// ===== design/deadline_timer_table.sv =====
// Deadline timer table top level: slot state, deadline and period memories,
// and the sequencer around the shared comparator. Depends on dtt_pkg, dtt_order_cmp.
//
// Usage: one request transaction on req_* carries a mode in req_tuser and its
// operands in req_tdata. Each request yields result transactions on rsp_*,
// the final one marked by rsp_tlast; a poll yields one per due slot, in
// deadline order. Mode 7 yields nothing.
// Sequence: mode 7 is dropped when accepted; cancel, cancel-all and rejected
// requests go straight to the output; add and reset arm the slot, then scan
// the table once; refresh first reads the period, then does the same; a query
// scans the table once; a poll scans for due slots, then scans once per due
// slot to find the next in order and re-arms each recurring slot it emits.
// Every scan reads one deadline per cycle through the single read port of
// the deadline memory and the one shared comparator.
// The block takes one request at a time; req_tready is high only when idle.
// Results sit in an output register; when rsp_tready is low the sequencer
// holds before loading the next result, so nothing is lost.
// Reset frees every slot and drops any pending result. Deadline and period
// memories are not cleared: their contents are used only for slots that were armed.
module deadline_timer_table
   import dtt_pkg::*;
#(
   parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [63:0] now_ms, [67:64] slot_id, [99:68] period_ms, [100] repeat_flag, rest zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [2:0] mode
   input  logic [MODE_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [3:0] slot_out, [67:4] wait_ms, [68] new_earliest, rest zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] status
   output logic [STATUS_W-1:0]   rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(NUM_SLOTS);

   function automatic logic [SLOT_ID_W-1:0] slot4(input logic [SLOT_W-1:0] s);
      logic [SLOT_W+SLOT_ID_W-1:0] ext;
      ext = {{SLOT_ID_W{1'b0}}, s};
      return ext[SLOT_ID_W-1:0];
   endfunction

   // request fields
   logic [NOW_W-1:0]     req_now;
   logic [SLOT_ID_W-1:0] req_sid;
   logic [PERIOD_W-1:0]  req_period;
   logic                 req_repeat;
   assign req_now    = req_tdata[63:0];
   assign req_sid    = req_tdata[67:64];
   assign req_period = req_tdata[99:68];
   assign req_repeat = req_tdata[100];

   // control and working registers
   state_type            state_ff, state_in;
   scan_type             kind_ff, kind_in;
   mode_type             mode_ff, mode_in;
   logic [NOW_W-1:0]     now_ff, now_in;
   logic [PERIOD_W-1:0]  period_ff, period_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [NOW_W-1:0]     arm_dl_ff, arm_dl_in;
   logic                 early_ff, early_in;
   logic [SLOT_W-1:0]    best_ff, best_in;
   logic [NOW_W-1:0]     best_dl_ff, best_dl_in;
   logic                 found_ff, found_in;
   logic [NUM_SLOTS-1:0] pend_ff, pend_in;
   logic [NUM_SLOTS-1:0] active_ff, active_in;
   logic [NUM_SLOTS-1:0] repeat_ff, repeat_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 dv_ff, dv_in;
   logic [SLOT_W-1:0]    didx_ff, didx_in;

   // pending single result
   status_type           res_status_ff, res_status_in;
   logic [SLOT_ID_W-1:0] res_slot_ff, res_slot_in;
   logic [NOW_W-1:0]     res_wait_ff, res_wait_in;
   logic                 res_ne_ff, res_ne_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [SLOT_ID_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [NOW_W-1:0]     rsp_wait_ff, rsp_wait_in;
   logic                 rsp_ne_ff, rsp_ne_in;
   logic                 rsp_last_ff, rsp_last_in;

   // memories
   logic [NOW_W-1:0]    dl_mem  [NUM_SLOTS];
   logic [PERIOD_W-1:0] per_mem [NUM_SLOTS];
   logic [NOW_W-1:0]    rd_dl_ff;
   logic [PERIOD_W-1:0] rd_per_ff;
   logic [SLOT_W-1:0]   raddr;
   logic                mem_we;
   logic [SLOT_W-1:0]   waddr;
   logic [NOW_W-1:0]    wdata_dl;
   logic [PERIOD_W-1:0] wdata_per;

   // shared comparator
   logic [NOW_W-1:0]  cmp_b_dl;
   logic [SLOT_W-1:0] cmp_b_idx;
   cmp_type           cmp;

   dtt_order_cmp #(
      .SLOT_W(SLOT_W)
   ) u_cmp (
      .a_dl (rd_dl_ff),
      .a_idx(didx_ff),
      .b_dl (cmp_b_dl),
      .b_idx(cmp_b_idx),
      .res  (cmp)
   );

   always_comb begin
      unique case (kind_ff)
         SCAN_EARLY: begin
            cmp_b_dl  = arm_dl_ff;
            cmp_b_idx = slot_ff;
         end
         SCAN_DUE: begin
            cmp_b_dl  = now_ff;
            cmp_b_idx = best_ff;
         end
         default: begin
            cmp_b_dl  = best_dl_ff;
            cmp_b_idx = best_ff;
         end
      endcase
   end

   // lowest free slot
   logic              free_found;
   logic [SLOT_W-1:0] free_idx;
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   // addressed slot
   logic [SLOT_W+SLOT_ID_W-1:0] sid_ext;
   logic [SLOT_W-1:0]           sid_idx;
   logic                        sid_bad;
   assign sid_ext = {{SLOT_W{1'b0}}, req_sid};
   assign sid_idx = sid_ext[SLOT_W-1:0];
   assign sid_bad = {{(32-SLOT_ID_W){1'b0}}, req_sid} >= 32'(NUM_SLOTS);

   // saturating arm adder
   logic [PERIOD_W-1:0] arm_per;
   logic [NOW_W:0]      arm_sum;
   logic [NOW_W-1:0]    arm_dl;
   assign arm_per = (mode_ff == MODE_ADD || mode_ff == MODE_RESET) ? period_ff : rd_per_ff;
   assign arm_sum = {1'b0, now_ff} + {{(NOW_W-PERIOD_W+1){1'b0}}, arm_per};
   assign arm_dl  = arm_sum[NOW_W] ? ALL_ONES_MS : arm_sum[NOW_W-1:0];

   logic out_free;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      logic                 cand;
      logic [NUM_SLOTS-1:0] pend_rest;
      logic [NOW_W:0]       diff;

      state_in      = state_ff;
      kind_in       = kind_ff;
      mode_in       = mode_ff;
      now_in        = now_ff;
      period_in     = period_ff;
      slot_in       = slot_ff;
      arm_dl_in     = arm_dl_ff;
      early_in      = early_ff;
      best_in       = best_ff;
      best_dl_in    = best_dl_ff;
      found_in      = found_ff;
      pend_in       = pend_ff;
      active_in     = active_ff;
      repeat_in     = repeat_ff;
      cnt_in        = cnt_ff;
      dv_in         = 1'b0;
      didx_in       = didx_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_wait_in   = res_wait_ff;
      res_ne_in     = res_ne_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_wait_in   = rsp_wait_ff;
      rsp_ne_in     = rsp_ne_ff;
      rsp_last_in   = rsp_last_ff;
      raddr         = slot_ff;
      mem_we        = 1'b0;
      waddr         = slot_ff;
      wdata_dl      = arm_dl;
      wdata_per     = arm_per;
      cand          = 1'b0;
      pend_rest     = pend_ff;
      diff          = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               mode_in     = mode_type'(req_tuser);
               now_in      = req_now;
               period_in   = req_period;
               res_status_in = STAT_OK;
               res_slot_in = '0;
               res_wait_in = '0;
               res_ne_in   = 1'b0;
               cnt_in      = '0;
               found_in    = 1'b0;
               unique case (req_tuser) inside
                  MODE_ADD: begin
                     if (free_found) begin
                        slot_in             = free_idx;
                        active_in[free_idx] = 1'b1;
                        repeat_in[free_idx] = req_repeat;
                        state_in            = S_ARM;
                     end else begin
                        res_status_in = STAT_FULL;
                        state_in      = S_OUT;
                     end
                  end
                  MODE_CANCEL, MODE_REFRESH, MODE_RESET: begin
                     res_slot_in = req_sid;
                     slot_in     = sid_idx;
                     if (sid_bad || !active_ff[sid_idx]) begin
                        res_status_in = STAT_INACTIVE;
                        state_in      = S_OUT;
                     end else if (req_tuser == MODE_CANCEL) begin
                        active_in[sid_idx] = 1'b0;
                        state_in           = S_OUT;
                     end else if (req_tuser == MODE_REFRESH) begin
                        state_in = S_PER;
                     end else begin
                        state_in = S_ARM;
                     end
                  end
                  MODE_POLL: begin
                     pend_in  = '0;
                     kind_in  = SCAN_DUE;
                     state_in = S_SCAN;
                  end
                  MODE_QUERY: begin
                     kind_in  = SCAN_MIN_ALL;
                     state_in = S_SCAN;
                  end
                  MODE_CANCEL_ALL: begin
                     active_in = '0;
                     state_in  = S_OUT;
                  end
                  default: begin
                     // unknown mode: drop it
                  end
               endcase
            end
         end

         S_SCAN: begin
            // issue one read per cycle; each result is checked in the cycle after its read
            if (cnt_ff < CNT_END) begin
               raddr   = cnt_ff[SLOT_W-1:0];
               dv_in   = 1'b1;
               didx_in = cnt_ff[SLOT_W-1:0];
               cnt_in  = cnt_ff + CNT_W'(1);
            end
            if (dv_ff) begin
               case (kind_ff)
                  SCAN_EARLY: begin
                     if (active_ff[didx_ff] && didx_ff != slot_ff && cmp.ahead)
                        early_in = 1'b0;
                  end
                  SCAN_DUE: begin
                     pend_in[didx_ff] = active_ff[didx_ff] && (cmp.lt || cmp.eq);
                  end
                  default: begin
                     cand = (kind_ff == SCAN_MIN_DUE) ? pend_ff[didx_ff] : active_ff[didx_ff];
                     if (cand && (!found_ff || cmp.ahead)) begin
                        found_in   = 1'b1;
                        best_in    = didx_ff;
                        best_dl_in = rd_dl_ff;
                     end
                  end
               endcase
            end
            if (cnt_ff == CNT_END) begin
               case (kind_ff)
                  SCAN_EARLY: begin
                     res_status_in = STAT_OK;
                     res_slot_in   = slot4(slot_ff);
                     res_ne_in     = early_in;
                     state_in      = S_OUT;
                  end
                  SCAN_DUE: begin
                     if (pend_in == '0) begin
                        res_status_in = STAT_NONE_DUE;
                        state_in      = S_OUT;
                     end else begin
                        kind_in  = SCAN_MIN_DUE;
                        cnt_in   = '0;
                        found_in = 1'b0;
                     end
                  end
                  SCAN_MIN_DUE: begin
                     state_in = S_EMIT;
                  end
                  default: begin
                     diff = {1'b0, best_dl_in} - {1'b0, now_ff};
                     if (!found_in) begin
                        res_wait_in = ALL_ONES_MS;
                        res_slot_in = '0;
                     end else begin
                        res_wait_in = diff[NOW_W] ? '0 : diff[NOW_W-1:0];
                        res_slot_in = slot4(best_in);
                     end
                     state_in = S_OUT;
                  end
               endcase
            end
         end

         S_EMIT: begin
            pend_rest          = pend_ff;
            pend_rest[best_ff] = 1'b0;
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_status_in    = STAT_OK;
               rsp_slot_in      = slot4(best_ff);
               rsp_wait_in      = '0;
               rsp_ne_in        = 1'b0;
               rsp_last_in      = (pend_rest == '0);
               pend_in          = pend_rest;
               cnt_in           = '0;
               found_in         = 1'b0;
               if (repeat_ff[best_ff]) begin
                  slot_in  = best_ff;
                  state_in = S_PER;
               end else begin
                  active_in[best_ff] = 1'b0;
                  state_in = (pend_rest == '0) ? S_IDLE : S_SCAN;
               end
            end
         end

         S_PER: begin
            raddr    = slot_ff;
            state_in = S_ARM;
         end

         S_ARM: begin
            mem_we    = 1'b1;
            arm_dl_in = arm_dl;
            cnt_in    = '0;
            found_in  = 1'b0;
            if (mode_ff == MODE_POLL) begin
               state_in = (pend_ff == '0) ? S_IDLE : S_SCAN;
            end else begin
               early_in = 1'b1;
               kind_in  = SCAN_EARLY;
               state_in = S_SCAN;
            end
         end

         S_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_wait_in   = res_wait_ff;
               rsp_ne_in     = res_ne_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= '0;
         repeat_ff    <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         repeat_ff    <= repeat_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      mode_ff       <= mode_in;
      now_ff        <= now_in;
      period_ff     <= period_in;
      slot_ff       <= slot_in;
      arm_dl_ff     <= arm_dl_in;
      early_ff      <= early_in;
      best_ff       <= best_in;
      best_dl_ff    <= best_dl_in;
      found_ff      <= found_in;
      pend_ff       <= pend_in;
      cnt_ff        <= cnt_in;
      didx_ff       <= didx_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_wait_ff   <= res_wait_in;
      res_ne_ff     <= res_ne_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_wait_ff   <= rsp_wait_in;
      rsp_ne_ff     <= rsp_ne_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // deadline and period memories: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         dl_mem[waddr]  <= wdata_dl;
         per_mem[waddr] <= wdata_per;
      end
      rd_dl_ff  <= dl_mem[raddr];
      rd_per_ff <= per_mem[raddr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-NOW_W-SLOT_ID_W-1){1'b0}}, rsp_ne_ff, rsp_wait_ff,
                        rsp_slot_ff};

endmodule

// ===== test/deadline_timer_table_test.sv =====
// Self-checking testbench for deadline_timer_table: a directed table, then random
// timer traffic under sender/receiver idling, checked by an in-bench timer predictor.
// Depends on dtt_pkg and the deadline_timer_table RTL.
module deadline_timer_table_test
   import dtt_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SLOTS = DEFAULT_NUM_SLOTS;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
   localparam int PHASE_ITEMS = 75;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 400;
   localparam int DRAIN_LIMIT = 200000;

   typedef struct {
      logic [MODE_W-1:0]    mode;
      logic [NOW_W-1:0]     now_ms;
      logic [SLOT_ID_W-1:0] slot_id;
      logic [PERIOD_W-1:0]  period_ms;
      logic                 repeat_flag;
   } timer_request_type;

   typedef struct {
      status_type           status;
      logic [SLOT_ID_W-1:0] slot_out;
      logic [NOW_W-1:0]     wait_ms;
      logic                 new_earliest;
      logic                 is_last;
   } timer_result_type;

   typedef struct {
      timer_request_type request;
      bit                typed;
      timer_result_type  want;
   } directed_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // [63:0] now_ms, [67:64] slot_id, [99:68] period_ms, [100] repeat_flag, rest zero
   logic [REQ_DATA_W-1:0] req_tdata;
   // [2:0] mode
   logic [MODE_W-1:0]     req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // [3:0] slot_out, [67:4] wait_ms, [68] new_earliest, rest zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // [1:0] status
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  rsp_tlast;

   // predicted timer table
   logic                timer_active   [NUM_SLOTS];
   logic                timer_repeat   [NUM_SLOTS];
   logic [PERIOD_W-1:0] timer_period   [NUM_SLOTS];
   logic [NOW_W-1:0]    timer_deadline [NUM_SLOTS];

   timer_result_type  step_results [$];
   timer_result_type  pending_results [$];
   timer_result_type  oldest_result;
   timer_result_type  no_typed_result;
   directed_row_type  directed_rows [$];
   logic [NOW_W-1:0] clock_ms;
   int mismatch_count;
   int send_idle_pct;
   int rsp_idle_pct;
   int hold_requests;
   int holds_served;

   deadline_timer_table #(.NUM_SLOTS(NUM_SLOTS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic logic [NOW_W-1:0] saturating_deadline(input logic [NOW_W-1:0] now_ms,
                                                            input logic [PERIOD_W-1:0] period);
      logic [NOW_W:0] sum;
      sum = {1'b0, now_ms} + {33'b0, period};
      return sum[NOW_W] ? ALL_ONES_MS : sum[NOW_W-1:0];
   endfunction

   // deadline order, lower slot wins a tie
   function automatic bit ahead_of(input int a, input int b);
      if (timer_deadline[a] != timer_deadline[b])
         return timer_deadline[a] < timer_deadline[b];
      return a < b;
   endfunction

   function automatic bit heads_order(input int s);
      for (int i = 0; i < NUM_SLOTS; i++)
         if (i != s && timer_active[i] && ahead_of(i, s))
            return 1'b0;
      return 1'b1;
   endfunction

   task automatic predict_timer_step(input timer_request_type r);
      bit due [NUM_SLOTS];
      int order [$];
      int best;
      bit found;
      int s;
      timer_result_type res;
      step_results.delete();
      res = '{STAT_OK, 4'd0, 64'd0, 1'b0, 1'b1};
      case (r.mode) inside
         MODE_ADD: begin
            found = 1'b0;
            for (int i = 0; i < NUM_SLOTS && !found; i++)
               if (!timer_active[i]) begin
                  timer_active[i] = 1'b1;
                  timer_repeat[i] = r.repeat_flag;
                  timer_period[i] = r.period_ms;
                  timer_deadline[i] = saturating_deadline(r.now_ms, r.period_ms);
                  res.slot_out = 4'(i);
                  res.new_earliest = heads_order(i);
                  found = 1'b1;
               end
            if (!found)
               res.status = STAT_FULL;
            step_results.insert(step_results.size(), res);
         end
         MODE_CANCEL, MODE_REFRESH, MODE_RESET: begin
            res.slot_out = r.slot_id;
            if (int'(r.slot_id) >= NUM_SLOTS || !timer_active[r.slot_id]) begin
               res.status = STAT_INACTIVE;
            end else if (r.mode == MODE_CANCEL) begin
               timer_active[r.slot_id] = 1'b0;
            end else begin
               if (r.mode == MODE_RESET)
                  timer_period[r.slot_id] = r.period_ms;
               timer_deadline[r.slot_id] =
                  saturating_deadline(r.now_ms, timer_period[r.slot_id]);
               res.new_earliest = heads_order(r.slot_id);
            end
            step_results.insert(step_results.size(), res);
         end
         MODE_POLL: begin
            for (int i = 0; i < NUM_SLOTS; i++)
               due[i] = timer_active[i] && timer_deadline[i] <= r.now_ms;
            // take the whole due order before any slot is re-armed
            do begin
               found = 1'b0;
               best = 0;
               for (int i = 0; i < NUM_SLOTS; i++)
                  if (due[i] && (!found || ahead_of(i, best))) begin
                     best = i;
                     found = 1'b1;
                  end
               if (found) begin
                  due[best] = 1'b0;
                  order.insert(order.size(), best);
               end
            end while (found);
            if (order.size() == 0) begin
               res.status = STAT_NONE_DUE;
               step_results.insert(step_results.size(), res);
            end
            foreach (order[k]) begin
               s = order[k];
               res.slot_out = 4'(s);
               res.is_last = (k == order.size() - 1);
               step_results.insert(step_results.size(), res);
               if (timer_repeat[s])
                  timer_deadline[s] = saturating_deadline(r.now_ms, timer_period[s]);
               else
                  timer_active[s] = 1'b0;
            end
         end
         MODE_QUERY: begin
            found = 1'b0;
            best = 0;
            for (int i = 0; i < NUM_SLOTS; i++)
               if (timer_active[i] && (!found || ahead_of(i, best))) begin
                  best = i;
                  found = 1'b1;
               end
            if (!found) begin
               res.wait_ms = ALL_ONES_MS;
            end else begin
               res.slot_out = 4'(best);
               res.wait_ms = (r.now_ms >= timer_deadline[best]) ? 64'd0 :
                             timer_deadline[best] - r.now_ms;
            end
            step_results.insert(step_results.size(), res);
         end
         MODE_CANCEL_ALL: begin
            for (int i = 0; i < NUM_SLOTS; i++)
               timer_active[i] = 1'b0;
            step_results.insert(step_results.size(), res);
         end
         default: ;
      endcase
   endtask

   // offer one request, hold it until accepted, then book its results
   task automatic send_timer_request(input timer_request_type r, input bit typed,
                                     input timer_result_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= r.mode;
      req_tdata <= {3'b0, r.repeat_flag, r.period_ms, r.slot_id, r.now_ms};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_timer_step(r);
      if (typed)
         pending_results.insert(pending_results.size(), want);
      else
         foreach (step_results[k])
            pending_results.insert(pending_results.size(), step_results[k]);
   endtask

   task automatic drain_results();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      // cover requests that give no result but may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_directed_row(input logic [MODE_W-1:0] mode,
                                     input logic [NOW_W-1:0] now_ms,
                                     input logic [SLOT_ID_W-1:0] slot_id,
                                     input logic [PERIOD_W-1:0] period_ms,
                                     input logic repeat_flag, input bit typed,
                                     input status_type status,
                                     input logic [SLOT_ID_W-1:0] slot_out,
                                     input logic [NOW_W-1:0] wait_ms,
                                     input logic new_earliest);
      directed_row_type row;
      row.request = '{mode, now_ms, slot_id, period_ms, repeat_flag};
      row.typed = typed;
      row.want = '{status, slot_out, wait_ms, new_earliest, 1'b1};
      directed_rows.insert(directed_rows.size(), row);
   endtask

   task automatic make_random_request(output timer_request_type r);
      int pick;
      int live [$];
      pick = $urandom_range(99);
      r.mode = pick < 26 ? MODE_ADD :
               pick < 36 ? MODE_CANCEL :
               pick < 48 ? MODE_REFRESH :
               pick < 60 ? MODE_RESET :
               pick < 80 ? MODE_POLL :
               pick < 94 ? MODE_QUERY :
               pick < 97 ? MODE_CANCEL_ALL : MODE_UNUSED;
      pick = $urandom_range(99);
      if (pick < 2) begin
         r.now_ms = ALL_ONES_MS;
      end else if (pick < 7) begin
         r.now_ms = {$urandom(), $urandom()};
      end else begin
         // mostly advance a running clock so deadlines come due
         clock_ms = clock_ms + 64'($urandom_range(0, 40));
         r.now_ms = clock_ms;
      end
      pick = $urandom_range(99);
      r.period_ms = pick < 80 ? PERIOD_W'($urandom_range(0, 120)) :
                    pick < 92 ? $urandom() :
                    pick < 96 ? '0 : '1;
      for (int i = 0; i < NUM_SLOTS; i++)
         if (timer_active[i])
            live.insert(live.size(), i);
      if (live.size() != 0 && $urandom_range(99) < 75)
         r.slot_id = 4'(live[$urandom_range(live.size() - 1)]);
      else
         r.slot_id = 4'($urandom_range(15));
      r.repeat_flag = 1'($urandom_range(1));
   endtask

   task automatic report_mismatch(input string field, input logic [NOW_W-1:0] want,
                                  input logic [NOW_W-1:0] got);
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t ns: unexpected result transaction, expected none, actual slot %0h",
                     $time, rsp_tdata[3:0]);
            mismatch_count++;
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_tuser !== oldest_result.status) begin
               report_mismatch("status", 64'(oldest_result.status), 64'(rsp_tuser));
               mismatch_count++;
            end
            if (rsp_tdata[3:0] !== oldest_result.slot_out) begin
               report_mismatch("slot_out", 64'(oldest_result.slot_out), 64'(rsp_tdata[3:0]));
               mismatch_count++;
            end
            if (rsp_tdata[67:4] !== oldest_result.wait_ms) begin
               report_mismatch("wait_ms", oldest_result.wait_ms, rsp_tdata[67:4]);
               mismatch_count++;
            end
            if (rsp_tdata[68] !== oldest_result.new_earliest) begin
               report_mismatch("new_earliest", 64'(oldest_result.new_earliest),
                               64'(rsp_tdata[68]));
               mismatch_count++;
            end
            if (rsp_tlast !== oldest_result.is_last) begin
               report_mismatch("last", 64'(oldest_result.is_last), 64'(rsp_tlast));
               mismatch_count++;
            end
            if (rsp_tdata[71:69] !== 3'b0) begin
               report_mismatch("padding", 64'd0, 64'(rsp_tdata[71:69]));
               mismatch_count++;
            end
         end
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_served) begin
            holds_served++;
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   initial begin
      timer_request_type item;
      int sent;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      mismatch_count = 0;
      hold_requests = 0;
      send_idle_pct = 32;
      rsp_idle_pct = 50;
      clock_ms = 64'd1000;
      no_typed_result = '{STAT_OK, 4'd0, 64'd0, 1'b0, 1'b1};
      for (int i = 0; i < NUM_SLOTS; i++) begin
         timer_active[i] = 1'b0;
         timer_repeat[i] = 1'b0;
         timer_period[i] = '0;
         timer_deadline[i] = '0;
      end

      // empty table, inactive slots, fill to full, re-arm, mass expiry
      queue_directed_row(MODE_QUERY, 64'd0, 4'd0, 32'd0, 1'b0, 1,
                         STAT_OK, 4'd0, ALL_ONES_MS, 1'b0);
      queue_directed_row(MODE_CANCEL, 64'd0, 4'd15, 32'd0, 1'b0, 1,
                         STAT_INACTIVE, 4'd15, 64'd0, 1'b0);
      queue_directed_row(MODE_REFRESH, 64'd0, 4'd0, 32'd0, 1'b0, 1,
                         STAT_INACTIVE, 4'd0, 64'd0, 1'b0);
      queue_directed_row(MODE_ADD, 64'd0, 4'd0, 32'd0, 1'b1, 1,
                         STAT_OK, 4'd0, 64'd0, 1'b1);
      // saturating deadline
      queue_directed_row(MODE_ADD, ALL_ONES_MS, 4'd0, '1, 1'b0, 1,
                         STAT_OK, 4'd1, 64'd0, 1'b0);
      for (int i = 2; i < NUM_SLOTS; i++)
         queue_directed_row(MODE_ADD, 64'(10 * i), 4'd0, 32'(7 * i), 1'(i % 2), 0,
                            STAT_OK, 4'd0, 64'd0, 1'b0);
      queue_directed_row(MODE_ADD, 64'd5, 4'd0, 32'd1, 1'b1, 1,
                         STAT_FULL, 4'd0, 64'd0, 1'b0);
      queue_directed_row(MODE_RESET, 64'd5, 4'd3, 32'd0, 1'b0, 0,
                         STAT_OK, 4'd0, 64'd0, 1'b0);
      queue_directed_row(MODE_POLL, 64'd1000, 4'd0, 32'd0, 1'b0, 0,
                         STAT_OK, 4'd0, 64'd0, 1'b0);
      queue_directed_row(MODE_UNUSED, 64'd1000, 4'd0, 32'd0, 1'b0, 0,
                         STAT_OK, 4'd0, 64'd0, 1'b0);
      queue_directed_row(MODE_CANCEL_ALL, 64'd1000, 4'd0, 32'd0, 1'b0, 1,
                         STAT_OK, 4'd0, 64'd0, 1'b0);
      queue_directed_row(MODE_POLL, 64'd0, 4'd0, 32'd0, 1'b0, 1,
                         STAT_NONE_DUE, 4'd0, 64'd0, 1'b0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[k])
         send_timer_request(directed_rows[k].request, directed_rows[k].typed,
                            directed_rows[k].want);
      drain_results();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = phase == 0 ? 32 : phase == 1 ? 50 : 0;
         rsp_idle_pct = phase == 0 ? 50 : phase == 1 ? 32 : 0;
         // keep offering while the receiver is held off
         if (phase == 2)
            hold_requests <= hold_requests + 1;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            make_random_request(item);
            send_timer_request(item, 0, no_typed_result);
            if (item.mode != MODE_UNUSED)
               sent++;
         end
         drain_results();
      end

      if (pending_results.size() != 0)
         $display("%0t ns: %0d expected results never arrived, expected 0 left, actual %0d",
                  $time, pending_results.size(), pending_results.size());
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/dtt_pkg.sv
design/dtt_order_cmp.sv
design/deadline_timer_table.sv
test/deadline_timer_table_test.sv
